// File: hw/rtl/tfdt_pkg.sv
// Shared constants and types for the triangle fragment depth test block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package tfdt_pkg;

    // Frame and depth format
    localparam int FRAME_WIDTH  = 512;
    localparam int FRAME_HEIGHT = 512;
    localparam int DEPTH_BITS   = 24;
    localparam int STORE_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ZADDR_W      = $clog2(STORE_SIZE);
    localparam int PIX_W        = 9;
    localparam int FRAME_CMP_W  = 14;

    // Fixed point widths
    localparam int COORD_W = 16;              // Q10.5 vertex coordinate
    localparam int DIFF_W  = COORD_W + 1;     // coordinate difference
    localparam int AREA_W  = 2 * DIFF_W + 1;  // doubled area, signed
    localparam int ABS_W   = AREA_W;          // magnitude of the area
    localparam int W_W     = AREA_W + 1;      // edge weight, signed
    localparam int MA_W    = 19;              // multiplier operand a
    localparam int MB_W    = 25;              // multiplier operand b
    localparam int PROD_W  = MA_W + MB_W;
    localparam int WLO_W   = 17;              // low split of a weight
    localparam int SUM_W   = 60;              // weighted depth sum
    localparam int REM_W   = ABS_W + 1;       // divider remainder

    // Configuration port
    localparam int CFG_DW     = 64;
    localparam int CFG_AW     = 5;
    localparam int VERT_W     = 56;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_FIRST  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_SECOND = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_THIRD  = 2'd2;

    // Input operations
    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = '1;

    // Triangle setup as seen by the raster sequencer
    typedef struct packed {
        logic [2:0][COORD_W-1:0]    vx;
        logic [2:0][COORD_W-1:0]    vy;
        logic [2:0][DEPTH_BITS-1:0] vz;
        logic [ABS_W-1:0]           area_abs;
        logic                       area_neg;
        logic                       busy;
    } t_geom;

    // Depth store access
    typedef struct packed {
        logic                  rd_en;
        logic [ZADDR_W-1:0]    rd_addr;
        logic                  wr_en;
        logic [ZADDR_W-1:0]    wr_addr;
        logic [DEPTH_BITS-1:0] wr_data;
    } t_zreq;

endpackage
`default_nettype wire

// File: hw/rtl/tfdt_cfg.sv
// Vertex registers behind the APB port and the doubled-area derivation.
// Depends on tfdt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfdt_cfg import tfdt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_geom                  o_geom
);

    logic [2:0][VERT_W-1:0] r_vert;
    logic [1:0]             r_phase;
    logic signed [2*DIFF_W-1:0] r_p0;
    logic [ABS_W-1:0]       r_abs;
    logic                   r_neg;

    logic                   wr_acc;
    logic [REG_IDX_W-1:0]   idx;
    logic signed [DIFF_W-1:0] ex1, ey1, ex2, ey2, ma, mb;
    logic signed [2*DIFF_W-1:0] prod;
    logic signed [AREA_W-1:0]   area;

    assign pready = 1'b1;
    assign wr_acc = psel & penable & pwrite & pready;
    assign idx    = paddr[CFG_AW-1:3];

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert <= '0;
        end else if (wr_acc) begin
            unique case (idx)
                REG_VERTEX_FIRST:  r_vert[0] <= pwdata[VERT_W-1:0];
                REG_VERTEX_SECOND: r_vert[1] <= pwdata[VERT_W-1:0];
                REG_VERTEX_THIRD:  r_vert[2] <= pwdata[VERT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_VERTEX_FIRST:  prdata = CFG_DW'(r_vert[0]);
            REG_VERTEX_SECOND: prdata = CFG_DW'(r_vert[1]);
            REG_VERTEX_THIRD:  prdata = CFG_DW'(r_vert[2]);
            default:           prdata = '0;
        endcase
    end

    // Edge vectors from vertex 0
    assign ex1 = DIFF_W'($signed(r_vert[1][15:0])) - DIFF_W'($signed(r_vert[0][15:0]));
    assign ey1 = DIFF_W'($signed(r_vert[1][31:16])) - DIFF_W'($signed(r_vert[0][31:16]));
    assign ex2 = DIFF_W'($signed(r_vert[2][15:0])) - DIFF_W'($signed(r_vert[0][15:0]));
    assign ey2 = DIFF_W'($signed(r_vert[2][31:16])) - DIFF_W'($signed(r_vert[0][31:16]));

    // One multiplier, two phases: ex1*ey2, then subtract ey1*ex2
    assign ma   = (r_phase == 2'd1) ? ex1 : ey1;
    assign mb   = (r_phase == 2'd1) ? ey2 : ex2;
    assign prod = ma * mb;
    assign area = AREA_W'(r_p0) - AREA_W'(prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_abs   <= '0;
            r_neg   <= 1'b0;
        end else begin
            if (wr_acc && idx != 2'd3) begin
                r_phase <= 2'd1;
            end else if (r_phase == 2'd1) begin
                r_phase <= 2'd2;
            end else if (r_phase == 2'd2) begin
                r_phase <= 2'd0;
                r_neg   <= area[AREA_W-1];
                r_abs   <= area[AREA_W-1] ? ABS_W'(-area) : ABS_W'(area);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == 2'd1) begin
            r_p0 <= prod;
        end
    end

    // Setup to the sequencer
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_geom.vx[i] = r_vert[i][15:0];
            o_geom.vy[i] = r_vert[i][31:16];
            o_geom.vz[i] = r_vert[i][32 +: DEPTH_BITS];
        end
        o_geom.area_abs = r_abs;
        o_geom.area_neg = r_neg;
        o_geom.busy     = (r_phase != 2'd0);
    end

endmodule
`default_nettype wire

// File: hw/rtl/tfdt_zmem.sv
// Depth store: one write port, one read port, registered read data.
// Depends on tfdt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfdt_zmem import tfdt_pkg::*; (
    input  wire logic         i_clk,
    input  wire t_zreq        i_req,
    output logic [DEPTH_BITS-1:0] o_rd_data
);

    logic [DEPTH_BITS-1:0] mem [STORE_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= mem[i_req.rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tfdt_raster.sv
// Per-pixel sequencer: edge weights, depth sum, serial divide, depth update.
// Depends on tfdt_pkg; drives the depth store in tfdt_zmem.
`timescale 1ns / 1ps
`default_nettype none
module tfdt_raster import tfdt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_geom                 i_geom,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_op,
    input  wire logic [PIX_W-1:0]      i_pixel_x,
    input  wire logic [PIX_W-1:0]      i_pixel_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_covered,
    output logic                       o_depth_written,
    output logic [DEPTH_BITS-1:0]      o_fragment_depth,
    output logic                       o_degenerate,
    output t_zreq                      o_zreq,
    input  wire logic [DEPTH_BITS-1:0] i_zold
);

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CROSS = 4'd2;
    localparam logic [3:0] S_TEST  = 4'd3;
    localparam logic [3:0] S_MAC   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_WRITE = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    localparam logic [4:0] LAST_TERM = 5'd5;
    localparam logic [4:0] LAST_DIV  = 5'(DEPTH_BITS - 1);
    localparam logic [ZADDR_W-1:0] LAST_ADDR = ZADDR_W'(STORE_SIZE - 1);

    logic [3:0]   r_state, n_state;
    logic [4:0]   r_cnt, n_cnt;
    logic [ZADDR_W-1:0] r_sweep, n_sweep;
    logic [ZADDR_W-1:0] r_addr, n_addr;
    logic [2:0][DIFF_W-1:0]     r_dx, n_dx, r_dy, n_dy;
    logic [2:0][W_W-1:0]        r_w, n_w;
    logic [2:0][DEPTH_BITS-1:0] r_z, n_z;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [DEPTH_BITS-1:0] r_quo, n_quo;
    logic [ABS_W-1:0]      r_abs, n_abs;
    logic                  r_neg, n_neg, r_degen, n_degen;
    logic                  r_cov, n_cov, r_wr, n_wr;
    logic                  r_out_valid, n_out_valid;
    logic                  r_o_cov, n_o_cov, r_o_wr, n_o_wr, r_o_degen, n_o_degen;
    logic [DEPTH_BITS-1:0] r_o_frag, n_o_frag;

    logic                  accept, inframe;
    logic [ZADDR_W-1:0]    pix_addr;
    logic [DIFF_W-1:0]     px, py;
    logic [1:0]            ti;
    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [PROD_W-1:0] prod;
    logic [W_W-1:0]        wsel;
    logic [REM_W-1:0]      trial;
    logic [SUM_W-1:0]      sum_next;

    assign o_in_stall = (r_state != S_IDLE) || i_geom.busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign inframe    = (FRAME_CMP_W'(i_pixel_x) < FRAME_CMP_W'(FRAME_WIDTH))
                     && (FRAME_CMP_W'(i_pixel_y) < FRAME_CMP_W'(FRAME_HEIGHT));
    assign pix_addr   = ZADDR_W'(i_pixel_y) * ZADDR_W'(FRAME_WIDTH) + ZADDR_W'(i_pixel_x);
    // Pixel center in Q10.5
    assign px = {1'b0, 2'b00, i_pixel_x, 5'b10000} >> 0;
    assign py = {1'b0, 2'b00, i_pixel_y, 5'b10000} >> 0;

    // Shared multiplier operand select
    assign ti   = r_cnt[2:1];
    assign wsel = r_w[ti];
    always_comb begin
        ma = '0;
        mb = '0;
        if (r_state == S_CROSS) begin
            case (r_cnt)
                5'd0: begin ma = MA_W'($signed(r_dx[1])); mb = MB_W'($signed(r_dy[2])); end
                5'd1: begin ma = MA_W'($signed(r_dx[2])); mb = MB_W'($signed(r_dy[1])); end
                5'd2: begin ma = MA_W'($signed(r_dx[2])); mb = MB_W'($signed(r_dy[0])); end
                5'd3: begin ma = MA_W'($signed(r_dx[0])); mb = MB_W'($signed(r_dy[2])); end
                5'd4: begin ma = MA_W'($signed(r_dx[0])); mb = MB_W'($signed(r_dy[1])); end
                default: begin
                    ma = MA_W'($signed(r_dx[1])); mb = MB_W'($signed(r_dy[0]));
                end
            endcase
        end else if (r_state == S_MAC) begin
            // Weights are nonnegative here and split into low and high parts
            if (r_cnt[0] == 1'b0) begin
                ma = $signed({2'b00, wsel[WLO_W-1:0]});
            end else begin
                ma = $signed({1'b0, wsel[ABS_W-1:WLO_W]});
            end
            mb = $signed({1'b0, r_z[ti]});
        end
    end
    assign prod = ma * mb;

    assign sum_next = r_cnt[0] ? r_sum + {prod[PROD_W-2:0], {WLO_W{1'b0}}}
                               : r_sum + SUM_W'(prod[PROD_W-2:0]);
    assign trial = {r_rem[REM_W-2:0], r_quo[DEPTH_BITS-1]};

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;     n_sweep = r_sweep; n_addr = r_addr;
        n_dx = r_dx;         n_dy = r_dy;       n_w = r_w;         n_z = r_z;
        n_sum = r_sum;       n_rem = r_rem;     n_quo = r_quo;     n_abs = r_abs;
        n_neg = r_neg;       n_degen = r_degen; n_cov = r_cov;     n_wr = r_wr;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_cov = r_o_cov;   n_o_wr = r_o_wr;   n_o_frag = r_o_frag; n_o_degen = r_o_degen;
        o_zreq.rd_en   = accept;
        o_zreq.rd_addr = pix_addr;
        o_zreq.wr_en   = 1'b0;
        o_zreq.wr_addr = r_addr;
        o_zreq.wr_data = DEPTH_FAR;

        unique case (r_state)
            // Clearing pass over the depth store after reset
            S_SWEEP: begin
                o_zreq.wr_en   = 1'b1;
                o_zreq.wr_addr = r_sweep;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_addr  = pix_addr;
                    n_degen = (i_geom.area_abs == '0);
                    n_abs   = i_geom.area_abs;
                    n_neg   = i_geom.area_neg;
                    n_z     = i_geom.vz;
                    for (int i = 0; i < 3; i++) begin
                        n_dx[i] = DIFF_W'($signed(i_geom.vx[i])) - px;
                        n_dy[i] = DIFF_W'($signed(i_geom.vy[i])) - py;
                    end
                    n_cov = 1'b0;
                    n_wr  = 1'b0;
                    n_quo = '0;
                    n_cnt = '0;
                    if (i_op == OP_CLEAR) begin
                        o_zreq.wr_en   = inframe;
                        o_zreq.wr_addr = pix_addr;
                        n_state = S_DONE;
                    end else if (i_geom.area_abs == '0 || !inframe) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CROSS;
                    end
                end
            end
            // Edge cross products, one product per cycle
            S_CROSS: begin
                if (r_cnt[0] == 1'b0) begin
                    n_w[ti] = prod[W_W-1:0];
                end else begin
                    n_w[ti] = r_w[ti] - prod[W_W-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_TERM) begin
                    n_state = S_TEST;
                end
            end
            // Orient weights and test coverage (edges count as inside)
            S_TEST: begin
                for (int i = 0; i < 3; i++) begin
                    n_w[i] = r_neg ? -r_w[i] : r_w[i];
                end
                n_sum = '0;
                n_cnt = '0;
                if (n_w[0][W_W-1] || n_w[1][W_W-1] || n_w[2][W_W-1]) begin
                    n_state = S_DONE;
                end else begin
                    n_cov   = 1'b1;
                    n_state = S_MAC;
                end
            end
            // Weighted depth sum, one partial product per cycle
            S_MAC: begin
                n_sum = sum_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_TERM) begin
                    n_rem   = sum_next[SUM_W-1:DEPTH_BITS] >> 0;
                    n_quo   = sum_next[DEPTH_BITS-1:0];
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            // Restoring divide, one quotient bit per cycle
            S_DIV: begin
                if (trial >= {1'b0, r_abs}) begin
                    n_rem = trial - {1'b0, r_abs};
                    n_quo = {r_quo[DEPTH_BITS-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_quo = {r_quo[DEPTH_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_DIV) begin
                    n_state = S_WRITE;
                end
            end
            // Depth test against the stored value
            S_WRITE: begin
                if (r_quo < i_zold) begin
                    o_zreq.wr_en   = 1'b1;
                    o_zreq.wr_data = r_quo;
                    n_wr = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_cov     = r_cov;
                    n_o_wr      = r_wr;
                    n_o_frag    = r_cov ? r_quo : '0;
                    n_o_degen   = r_degen;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;   r_dx <= n_dx;       r_dy <= n_dy;   r_w <= n_w;
        r_z <= n_z;         r_sum <= n_sum;     r_rem <= n_rem; r_quo <= n_quo;
        r_abs <= n_abs;     r_neg <= n_neg;     r_degen <= n_degen;
        r_cov <= n_cov;     r_wr <= n_wr;
        r_o_cov <= n_o_cov; r_o_wr <= n_o_wr;   r_o_frag <= n_o_frag;
        r_o_degen <= n_o_degen;
    end

    assign o_out_valid      = r_out_valid;
    assign o_covered        = r_o_cov;
    assign o_depth_written  = r_o_wr;
    assign o_fragment_depth = r_o_frag;
    assign o_degenerate     = r_o_degen;

endmodule
`default_nettype wire

// File: hw/rtl/triangle_fragment_depth_test_unit.sv
// Top level of the triangle fragment depth test block.
// Depends on tfdt_pkg, tfdt_cfg, tfdt_zmem and tfdt_raster.
//
// Use: write the three vertices over the APB port (64-bit data, vertex n at
// byte address 8*n). After each vertex write the doubled area is derived,
// during which the pixel channel stalls. Pixel items (op, x, y) enter on the
// input channel when valid is high and stall is low; each item gives exactly
// one result item on the output channel.
// Path: a clear, an off-frame pixel or a degenerate triangle goes straight to
// the result; an uncovered pixel first takes the edge products; a covered
// pixel takes edge products and depth sums on one shared multiplier, then a
// one-bit-per-cycle divide and a depth store read-modify-write.
// One item is in work at a time. A finished result waits in an output
// register while the next item is accepted; if the receiver stalls, the
// sequencer holds its next result until the register is free.
// Reset clears the vertices and then sweeps all 262144 depth store entries to
// farthest, one entry a cycle; no item is accepted during the sweep.
`timescale 1ns / 1ps
`default_nettype none
module triangle_fragment_depth_test_unit import tfdt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_AW-1:0]     paddr,
    input  wire logic [CFG_DW-1:0]     pwdata,
    output logic      [CFG_DW-1:0]     prdata,
    output logic                       pready,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_op,
    input  wire logic [PIX_W-1:0]      i_pixel_x,
    input  wire logic [PIX_W-1:0]      i_pixel_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_covered,
    output logic                       o_depth_written,
    output logic [DEPTH_BITS-1:0]      o_fragment_depth,
    output logic                       o_degenerate
);

    t_geom                 geom;
    t_zreq                 zreq;
    logic [DEPTH_BITS-1:0] zold;

    tfdt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    tfdt_zmem u_zmem (
        .i_clk     (i_clk),
        .i_req     (zreq),
        .o_rd_data (zold)
    );

    tfdt_raster u_raster (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_geom           (geom),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_covered        (o_covered),
        .o_depth_written  (o_depth_written),
        .o_fragment_depth (o_fragment_depth),
        .o_degenerate     (o_degenerate),
        .o_zreq           (zreq),
        .i_zold           (zold)
    );

endmodule
`default_nettype wire
